// File: hw/rtl/skit_pkg.sv
// shared types and codes for the sorted key index table
`default_nettype none
package skit_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOTFD = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int KEY_W = 32;
  localparam int POS_W = 21;
  localparam int SLOT_W = 8;
  localparam int ENT_W = 9;
  localparam int BASE_W = 16;
  localparam int STRIDE_W = 13;
  localparam int CFG_W = 16;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_STRIDE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RST = 16'd32;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd128;

  // memory access request from the controller to the store
  typedef struct packed {
    logic we;
    logic [KEY_W-1:0] wkey;
    logic [POS_W-1:0] wpos;
  } mem_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/skit_store.sv
// key and position memory, one port, registered read
`default_nettype none
module skit_store import skit_pkg::*; #(
  parameter int AW = 8
) (
  input  wire logic            clk,
  input  wire logic [AW-1:0]   addr,
  input  wire mem_ctl_t        ctl,
  output logic [KEY_W-1:0]     rkey,
  output logic [POS_W-1:0]     rpos
);
  logic [KEY_W+POS_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= {ctl.wkey, ctl.wpos};
    end
    {rkey, rpos} <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/sorted_key_index_table.sv
// sorted key index table top level: sequencer over one key/position memory
// Usage: pulse start with in_op/in_key while busy is low. The table binary
// searches its memory (each probe reads an entry in S_SRD and compares it in
// S_SCMP), then an insert shifts later entries up and a delete shifts them
// down, one entry at a time (read state, then write state). The answer
// appears on out_* for one cycle with out_valid; the receiver cannot stall,
// so busy only reflects work. busy drops in the out_valid cycle, so the next
// command can be taken there: one command at a time, no overlap.
// Write cfg_* only while busy is low: index 0 base_offset, 1 record_stride.
// Reset clears the count and restores base 32 and stride 128; memory
// contents are not cleared since only the first count entries are used.
// New positions are base_offset + record_stride*count, low 21 bits.
`default_nettype none
module sorted_key_index_table import skit_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_op,
  input  wire logic signed [31:0]  in_key,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [POS_W-1:0]         out_position,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [ENT_W-1:0]         out_entries
);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_HRD, S_HCHK, S_MUL, S_IRD, S_IWR, S_INEW,
    S_DRD, S_DWR, S_DONE
  } state_t;

  state_t state_r;
  logic [BASE_W-1:0] base_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, idx_r;
  op_t op_r;
  logic [KEY_W-1:0] key_r;
  logic [POS_W-1:0] newpos_r;
  logic [AW-1:0] addr;
  mem_ctl_t ctl;
  logic [KEY_W-1:0] rkey;
  logic [POS_W-1:0] rpos;
  logic [CW-1:0] mid;
  logic [STRIDE_W+CW-1:0] prod;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign prod = stride_r * cnt_r;
  assign busy = (state_r != S_IDLE);

  skit_store #(.AW(AW)) u_store (
    .clk(clk), .addr(addr), .ctl(ctl), .rkey(rkey), .rpos(rpos)
  );

  always_comb begin
    addr = idx_r[AW-1:0];
    ctl.we = 1'b0;
    ctl.wkey = rkey;
    ctl.wpos = rpos;
    case (state_r)
      S_SRD: addr = mid[AW-1:0];
      S_HRD: addr = lo_r[AW-1:0];
      S_IWR: begin
        ctl.we = 1'b1;
        addr = AW'(idx_r + 1'b1);
      end
      S_DWR: begin
        ctl.we = 1'b1;
        addr = AW'(idx_r - 1'b1);
      end
      S_INEW: begin
        ctl.we = 1'b1;
        addr = lo_r[AW-1:0];
        ctl.wkey = key_r;
        ctl.wpos = newpos_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r <= BASE_RST;
      stride_r <= STRIDE_RST;
      cnt_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_r <= cfg_data;
        else stride_r <= cfg_data[STRIDE_W-1:0];
      end
      case (state_r)
        S_IDLE: if (start) begin
          op_r <= op_t'(in_op);
          key_r <= in_key;
          lo_r <= '0;
          hi_r <= cnt_r;
          state_r <= S_SRD;
        end
        S_SRD: state_r <= (lo_r < hi_r) ? S_SCMP : S_HRD;
        S_SCMP: begin
          if ($signed(rkey) < $signed(key_r)) lo_r <= mid + 1'b1;
          else hi_r <= mid;
          state_r <= S_SRD;
        end
        S_HRD: state_r <= S_HCHK; // read slot lo
        S_HCHK: begin
          out_status <= ST_NOTFD;
          out_position <= '0;
          out_slot <= '0;
          out_entries <= ENT_W'(cnt_r);
          state_r <= S_DONE;
          if (lo_r < cnt_r && rkey == key_r) begin
            out_position <= rpos;
            out_slot <= SLOT_W'(lo_r);
            case (op_r)
              OP_LOOKUP: out_status <= ST_OK;
              OP_INSERT: out_status <= ST_DUP;
              OP_DELETE: begin
                out_status <= ST_OK;
                idx_r <= lo_r + 1'b1;
                state_r <= S_DRD;
              end
              default: begin
                out_position <= '0;
                out_slot <= '0;
              end
            endcase
          end else if (op_r == OP_INSERT) begin
            if (cnt_r >= CW'(MAX_ENTRIES)) begin
              out_status <= ST_FULL;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          newpos_r <= POS_W'(base_r + prod);
          idx_r <= cnt_r - 1'b1;
          state_r <= (cnt_r > lo_r) ? S_IRD : S_INEW;
        end
        S_IRD: state_r <= S_IWR;
        S_IWR: begin
          // moved idx to idx+1
          idx_r <= idx_r - 1'b1;
          state_r <= (idx_r > lo_r) ? S_IRD : S_INEW;
        end
        S_INEW: begin
          cnt_r <= cnt_r + 1'b1;
          out_status <= ST_OK;
          out_position <= newpos_r;
          out_slot <= SLOT_W'(lo_r);
          out_entries <= ENT_W'(cnt_r + 1'b1);
          state_r <= S_DONE;
        end
        S_DRD: begin
          if (idx_r < cnt_r) state_r <= S_DWR;
          else begin
            cnt_r <= cnt_r - 1'b1;
            out_entries <= ENT_W'(cnt_r - 1'b1);
            state_r <= S_DONE;
          end
        end
        S_DWR: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_DRD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skit_checker.sv
// port-level checks for the sorted key index table, bound to the top level
`default_nettype none
module skit_checker import skit_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic [1:0] out_status,
  input wire logic [POS_W-1:0] out_position,
  input wire logic [ENT_W-1:0] out_entries
);
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than a beat");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_position == '0)
    else $error("full with position");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("work ended without result");
endmodule

bind sorted_key_index_table skit_checker u_skit_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_position(out_position), .out_entries(out_entries)
);
`default_nettype wire
